// ===== sv/bprsgd_pkg.sv =====
// bprsgd_pkg: shared constants, types and the one-minus-sigmoid table
// used by the bpr sgd step unit; depends on nothing

package bprsgd_pkg;

    localparam int MaxFactors = 32;
    localparam int UserRows   = 1024;
    localparam int ItemRows   = 4096;
    localparam int FW         = $clog2(MaxFactors);
    localparam int UAW        = $clog2(UserRows) + FW;
    localparam int IAW        = $clog2(ItemRows) + FW;

    localparam logic [2:0] CMD_TRAIN   = 3'd0;
    localparam logic [2:0] CMD_WR_USER = 3'd1;
    localparam logic [2:0] CMD_WR_ITEM = 3'd2;
    localparam logic [2:0] CMD_RD_USER = 3'd3;
    localparam logic [2:0] CMD_RD_ITEM = 3'd4;

    localparam logic [2:0] REG_LEARN_RATE   = 3'd0;
    localparam logic [2:0] REG_REG_USER     = 3'd1;
    localparam logic [2:0] REG_REG_POS_ITEM = 3'd2;
    localparam logic [2:0] REG_REG_NEG_ITEM = 3'd3;
    localparam logic [2:0] REG_FACTORS_USED = 3'd4;

    // request from the sequencer to the shared update unit
    typedef struct packed {
        logic               start;
        logic signed [15:0] v;
        logic signed [16:0] dv;     // gradient factor before delta
        logic        [15:0] lam;
    } upd_req_t;

    // one minus sigmoid over x in [-8, 8) in steps of 1/16, built at elaboration
    function automatic logic [255:0][12:0] build_sig_table();
        logic [255:0][12:0] tbl;
        logic [63:0] e;
        logic [63:0] den;
        logic [63:0] rem;
        logic [12:0] q;
        tbl = '0;
        e   = 64'd1 << 30;
        for (int j = 0; j <= 128; j++) begin
            den = (64'd1 << 30) + e;
            rem = 64'd8192 * e + den;
            q   = '0;
            // restoring quotient of rem over 2*den, it stays below 2^13
            for (int b = 12; b >= 0; b--) begin
                if (rem >= ((64'd2 * den) << b)) begin
                    rem  = rem - ((64'd2 * den) << b);
                    q[b] = 1'b1;
                end
            end
            if (j < 128) tbl[128 + j] = q;
            if (j > 0) tbl[128 - j] = 13'd4096 - q;
            e = (e * 64'd1008687096 + (64'd1 << 29)) >> 30;
        end
        return tbl;
    endfunction

    localparam logic [255:0][12:0] SigTable = build_sig_table();

endpackage

// ===== sv/bprsgd_mac.sv =====
// bprsgd_mac: shared multiply unit for the element updates
// depends on bprsgd_pkg; an update runs through the phases below, one product in each but the last

module bprsgd_mac (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  bprsgd_pkg::upd_req_t      req,
    input  logic [12:0]               delta,
    input  logic [15:0]               eta,
    output logic                      done,
    output logic signed [15:0]        result
);
    logic [2:0]          ph_reg;
    logic signed [31:0]  g_reg;
    logic signed [36:0]  t_reg;
    logic signed [15:0]  v_reg;
    logic [15:0]         lam_reg;
    logic signed [16:0]  dv_reg;
    logic signed [54:0]  p_reg;
    logic signed [63:0]  s_full;
    logic signed [33:0]  sum;

    // ph 1: g = delta*dv; 2: t = 16g - lam*v (one multiply); 3: eta*t; 4: round/sat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg <= '0;
        end else if (req.start) begin
            ph_reg <= 3'd1;
        end else if (ph_reg != 3'd0) begin
            ph_reg <= (ph_reg == 3'd4) ? 3'd0 : ph_reg + 3'd1;
        end
        if (req.start) begin
            v_reg   <= req.v;
            dv_reg  <= req.dv;
            lam_reg <= req.lam;
        end
        unique case (ph_reg)
            3'd1: g_reg <= 32'($signed({1'b0, delta}) * dv_reg);
            3'd2: t_reg <= 37'(($signed({{5{g_reg[31]}}, g_reg}) <<< 4)
                           - $signed({1'b0, lam_reg}) * v_reg);
            3'd3: p_reg <= 55'($signed({1'b0, eta}) * t_reg);
            default: ;
        endcase
    end

    assign s_full = (64'(p_reg) + 64'sd2147483648) >>> 32;
    assign sum    = 34'(s_full) + 34'(v_reg);
    assign done   = (ph_reg == 3'd4);
    assign result = (sum > 34'sd32767) ? 16'sd32767 :
                    (sum < -34'sd32768) ? -16'sd32768 : sum[15:0];
endmodule

// ===== sv/bpr_matrix_factor_sgd_step_unit.sv =====
// bpr_matrix_factor_sgd_step_unit: top level with tables, sequencer and registers
// depends on bprsgd_pkg and bprsgd_mac
//
// channel | dir | fields
// s_axis  | in  | tuser: command; tdata: user_row, pos_row, neg_row, factor_sel, write_value
// m_axis  | out | tdata: read_value, delta_out
// cfg     | in  | cfg_index, cfg_data
//
// a write or unknown command goes from decode straight to the result; a read passes
// through a read wait state first; train over n factors runs the dot product (issue pos
// read, issue neg read, accumulate per factor), the table lookup, then three update passes
// per factor: two table reads, start of the shared update unit, wait for it, write back
// s_tready is low from acceptance until the cycle after the result transfer
// no clearing pass, tables are undefined until written; reset is synchronous

module bpr_matrix_factor_sgd_step_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // command[2:0]
    input  logic [2:0]  s_tuser,
    // user_row[9:0] pos_row[21:10] neg_row[33:22] factor_sel[38:34] write_value[54:39]
    input  logic [55:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_value[15:0] delta_out[28:16]
    output logic [31:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    localparam int FW = bprsgd_pkg::FW;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_RDWAIT, S_DOT_A, S_DOT_B, S_DOT_C, S_LUT,
        S_UPD_A, S_UPD_B, S_UPD_C, S_UPD_D, S_UPD_E, S_OUT
    } state_t;

    logic signed [15:0] umem [0:(1 << bprsgd_pkg::UAW) - 1];
    logic signed [15:0] imem [0:(1 << bprsgd_pkg::IAW) - 1];

    state_t state_reg;
    logic [15:0] eta_reg, lu_reg, lp_reg, ln_reg;
    logic [5:0]  fu_reg;
    logic [2:0]  cmd_reg;
    logic [9:0]  ur_reg;
    logic [11:0] pr_reg, nr_reg;
    logic [4:0]  fs_reg;
    logic signed [15:0] wv_reg;
    logic [5:0]  n_reg, f_reg;
    logic [1:0]  pass_reg;            // 0 user, 1 pos, 2 neg
    logic signed [40:0] acc_reg;
    logic [12:0] delta_reg;
    logic signed [15:0] u_rd, i_rd, u_v, p_v;
    logic        ib_reg;              // which item read is in flight
    logic signed [15:0] rv_reg;
    logic        m_valid_reg;
    logic [7:0]  idx;

    // memory ports
    logic               u_we, i_we;
    logic [bprsgd_pkg::UAW-1:0] u_addr;
    logic [bprsgd_pkg::IAW-1:0] i_addr;
    logic signed [15:0] u_wd, i_wd;

    bprsgd_pkg::upd_req_t req;
    logic               upd_done;
    logic signed [15:0] upd_res;

    bprsgd_mac u_mac (
        .aclk(aclk), .aresetn(aresetn), .req(req), .delta(delta_reg),
        .eta(eta_reg), .done(upd_done), .result(upd_res)
    );

    always_ff @(posedge aclk) begin
        if (u_we) umem[u_addr] <= u_wd;
        u_rd <= umem[u_addr];
        if (i_we) imem[i_addr] <= i_wd;
        i_rd <= imem[i_addr];
    end

    logic [11:0] irow;
    always_comb begin
        irow   = (state_reg == S_DOT_A || state_reg == S_DOT_C || ib_reg) ? nr_reg : pr_reg;
        u_we   = 1'b0;
        i_we   = 1'b0;
        u_wd   = wv_reg;
        i_wd   = wv_reg;
        u_addr = {ur_reg, (state_reg == S_DECODE) ? fs_reg : f_reg[FW-1:0]};
        i_addr = {pr_reg, (state_reg == S_DECODE) ? fs_reg : f_reg[FW-1:0]};
        if (state_reg == S_DOT_A || state_reg == S_DOT_B || state_reg == S_UPD_A
            || state_reg == S_UPD_B || state_reg == S_UPD_E) begin
            i_addr = {irow, f_reg[FW-1:0]};
        end
        if (state_reg == S_DECODE) begin
            u_we = (cmd_reg == bprsgd_pkg::CMD_WR_USER);
            i_we = (cmd_reg == bprsgd_pkg::CMD_WR_ITEM);
        end
        if (state_reg == S_UPD_E) begin
            if (pass_reg == 2'd0) begin
                u_we = 1'b1;
                u_wd = upd_res;
            end else begin
                i_we   = 1'b1;
                i_wd   = upd_res;
                i_addr = {(pass_reg == 2'd1) ? pr_reg : nr_reg, f_reg[FW-1:0]};
            end
        end
        // lut index from the Q.24 score
        if (acc_reg < -41'sd134217728) idx = 8'd0;
        else if (acc_reg >= 41'sd134217728) idx = 8'd255;
        else idx = 8'(41'(acc_reg + 41'sd134217728) >>> 20);
        // in C the neg element sits on the item read port, so it is taken from there
        req.start = (state_reg == S_UPD_C);
        req.lam   = (pass_reg == 2'd0) ? lu_reg : (pass_reg == 2'd1) ? lp_reg : ln_reg;
        req.v     = (pass_reg == 2'd0) ? u_v : (pass_reg == 2'd1) ? p_v : i_rd;
        req.dv    = (pass_reg == 2'd0) ? 17'(p_v) - 17'(i_rd) :
                    (pass_reg == 2'd1) ? 17'(u_v) : -17'(u_v);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            eta_reg <= 16'd655; lu_reg <= 16'd655; lp_reg <= 16'd655; ln_reg <= 16'd655;
            fu_reg  <= 6'd32;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    bprsgd_pkg::REG_LEARN_RATE:   eta_reg <= cfg_data;
                    bprsgd_pkg::REG_REG_USER:     lu_reg  <= cfg_data;
                    bprsgd_pkg::REG_REG_POS_ITEM: lp_reg  <= cfg_data;
                    bprsgd_pkg::REG_REG_NEG_ITEM: ln_reg  <= cfg_data;
                    bprsgd_pkg::REG_FACTORS_USED: fu_reg  <= cfg_data[5:0];
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_IDLE: if (s_tvalid) begin
                    cmd_reg <= s_tuser;         ur_reg <= s_tdata[9:0];
                    pr_reg  <= s_tdata[21:10];  nr_reg <= s_tdata[33:22];
                    fs_reg  <= s_tdata[38:34];  wv_reg <= s_tdata[54:39];
                    state_reg <= S_DECODE;
                end
                S_DECODE: begin
                    rv_reg    <= '0;
                    delta_reg <= '0;
                    acc_reg   <= '0;
                    f_reg     <= '0;
                    pass_reg  <= '0;
                    ib_reg    <= 1'b0;
                    n_reg     <= (fu_reg > 6'd32) ? 6'd32 : fu_reg;
                    if (cmd_reg == bprsgd_pkg::CMD_TRAIN) begin
                        state_reg <= (fu_reg == 6'd0) ? S_LUT : S_DOT_B;
                    end else if (cmd_reg == bprsgd_pkg::CMD_RD_USER
                                 || cmd_reg == bprsgd_pkg::CMD_RD_ITEM) begin
                        state_reg <= S_RDWAIT;
                    end else begin
                        state_reg <= S_OUT;
                    end
                end
                S_RDWAIT: begin
                    rv_reg    <= (cmd_reg == bprsgd_pkg::CMD_RD_USER) ? u_rd : i_rd;
                    state_reg <= S_OUT;
                end
                // dot: B issues pos read, A issues neg read, C accumulates
                S_DOT_B: state_reg <= S_DOT_A;
                S_DOT_A: begin
                    p_v <= i_rd; u_v <= u_rd;
                    state_reg <= S_DOT_C;
                end
                S_DOT_C: begin
                    acc_reg <= acc_reg + 41'(u_v * (18'(p_v) - 18'(i_rd)));
                    if (f_reg + 6'd1 >= n_reg) begin
                        f_reg <= '0; state_reg <= S_LUT;
                    end else begin
                        f_reg <= f_reg + 6'd1; state_reg <= S_DOT_B;
                    end
                end
                S_LUT: begin
                    if (cmd_reg == bprsgd_pkg::CMD_TRAIN) delta_reg <= bprsgd_pkg::SigTable[idx];
                    state_reg <= (n_reg == 6'd0) ? S_OUT : S_UPD_A;
                end
                // update: A reads pos, B reads neg (user in both), C starts unit
                S_UPD_A: begin ib_reg <= 1'b1; state_reg <= S_UPD_B; end
                S_UPD_B: begin p_v <= i_rd; u_v <= u_rd; ib_reg <= 1'b0;
                    state_reg <= S_UPD_C; end
                S_UPD_C: state_reg <= S_UPD_D;
                S_UPD_D: if (upd_done) state_reg <= S_UPD_E;
                S_UPD_E: begin
                    if (f_reg + 6'd1 >= n_reg) begin
                        f_reg <= '0;
                        if (pass_reg == 2'd2) state_reg <= S_OUT;
                        else begin pass_reg <= pass_reg + 2'd1; state_reg <= S_UPD_A; end
                    end else begin
                        f_reg <= f_reg + 6'd1; state_reg <= S_UPD_A;
                    end
                end
                S_OUT: begin
                    if (!m_valid_reg) m_valid_reg <= 1'b1;
                    else if (m_tready) begin m_valid_reg <= 1'b0; state_reg <= S_IDLE; end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {3'd0, delta_reg, rv_reg};
endmodule

// ===== sv/bprsgd_checker.sv =====
// bprsgd_checker: port level checks on the step unit, bound to the top level
// depends on bpr_matrix_factor_sgd_step_unit ports only

module bprsgd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("ready while result pending");
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[31:29] == 3'd0) else $error("pad bits set");
    a_delta: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[28:16] <= 13'd4096) else $error("delta range");
endmodule

bind bpr_matrix_factor_sgd_step_unit bprsgd_checker u_chk (.*);
